### rtl/best_master_record_select_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the best master record selector.
// ---------------------------------------------------------------------------
`ifndef BEST_MASTER_RECORD_SELECT_ASSERT_SVH
`define BEST_MASTER_RECORD_SELECT_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define BMRS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define BMRS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/bmrs_pkg.sv
// ---------------------------------------------------------------------------
// bmrs_pkg
// Types and the dataset comparison used by the best master record selector.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmrs_pkg;

	// One announce record as it is held in the input stage and the kept slot.
	typedef struct packed {
		logic [63:0] gm_identity;
		logic [7:0]  gm_priority1;
		logic [7:0]  gm_clock_class;
		logic [7:0]  gm_clock_accuracy;
		logic [15:0] gm_log_variance;
		logic [7:0]  gm_priority2;
		logic [15:0] hop_count;
		logic [63:0] sender_identity;
		logic [63:0] receiver_identity;
		logic [15:0] receiver_port;
		logic [7:0]  record_tag;
	} record_t;

	// Outcome of comparing a new record A with the kept record B.
	typedef enum logic [2:0] {
		CMP_A_BETTER,
		CMP_A_TOPO,
		CMP_B_BETTER,
		CMP_B_TOPO,
		CMP_ERROR
	} cmp_t;

	// Dataset comparison of new record a against kept record b.
	function automatic cmp_t compare_rec(record_t a, record_t b);
		logic [16:0] hop_a;
		logic [16:0] hop_b;
		cmp_t        r;
		hop_a = {1'b0, a.hop_count};
		hop_b = {1'b0, b.hop_count};
		if (a.gm_identity != b.gm_identity) begin
			// Different grandmasters: first differing quality field decides.
			priority if (a.gm_priority1 != b.gm_priority1)
				r = (a.gm_priority1 < b.gm_priority1) ? CMP_A_BETTER : CMP_B_BETTER;
			else if (a.gm_clock_class != b.gm_clock_class)
				r = (a.gm_clock_class < b.gm_clock_class) ? CMP_A_BETTER : CMP_B_BETTER;
			else if (a.gm_clock_accuracy != b.gm_clock_accuracy)
				r = (a.gm_clock_accuracy < b.gm_clock_accuracy) ?
					CMP_A_BETTER : CMP_B_BETTER;
			else if (a.gm_log_variance != b.gm_log_variance)
				r = (a.gm_log_variance < b.gm_log_variance) ? CMP_A_BETTER : CMP_B_BETTER;
			else if (a.gm_priority2 != b.gm_priority2)
				r = (a.gm_priority2 < b.gm_priority2) ? CMP_A_BETTER : CMP_B_BETTER;
			else
				r = (a.gm_identity < b.gm_identity) ? CMP_A_BETTER : CMP_B_BETTER;
		end else begin
			// Same grandmaster: topology decides.
			priority if (hop_a > hop_b + 17'd1)
				r = CMP_B_BETTER;
			else if (hop_a + 17'd1 < hop_b)
				r = CMP_A_BETTER;
			else if (hop_a > hop_b) begin
				priority if (a.receiver_identity < a.sender_identity)
					r = CMP_B_BETTER;
				else if (a.receiver_identity > a.sender_identity)
					r = CMP_B_TOPO;
				else
					r = CMP_ERROR;
			end else if (hop_a < hop_b) begin
				priority if (b.receiver_identity < b.sender_identity)
					r = CMP_A_BETTER;
				else if (b.receiver_identity > b.sender_identity)
					r = CMP_A_TOPO;
				else
					r = CMP_ERROR;
			end else if (a.sender_identity < b.sender_identity)
				r = CMP_A_TOPO;
			else if (a.sender_identity > b.sender_identity)
				r = CMP_B_TOPO;
			else if (a.receiver_port > b.receiver_port)
				r = CMP_B_TOPO;
			else if (a.receiver_port < b.receiver_port)
				r = CMP_A_TOPO;
			else
				r = CMP_ERROR;
		end
		return r;
	endfunction

endpackage

### rtl/best_master_record_select.sv
// ---------------------------------------------------------------------------
// best_master_record_select
// Keeps the best of a list of announce records using the dataset comparison.
// ---------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  input    in_valid / in_ready   one announce record, last_record ends a list
//  output   out_valid / out_ready chosen_tag, failed (one per list)
//
//  One record per cycle unless the input stage stalls: a record is compared
//  with the kept record in the cycle after its transfer, one pass through the
//  comparison chain. A list result is written to the output register when its
//  last record leaves the input stage. The input stage stalls only when it holds
//  a last record while an earlier result still waits in the output register.
//  Reset clears the handshake state and starts a new list.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module best_master_record_select (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] gm_identity,
	input  logic [7:0]  gm_priority1,
	input  logic [7:0]  gm_clock_class,
	input  logic [7:0]  gm_clock_accuracy,
	input  logic [15:0] gm_log_variance,
	input  logic [7:0]  gm_priority2,
	input  logic [15:0] hop_count,
	input  logic [63:0] sender_identity,
	input  logic [63:0] receiver_identity,
	input  logic [15:0] receiver_port,
	input  logic [7:0]  record_tag,
	input  logic        last_record,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  chosen_tag,
	output logic        failed
);
	import bmrs_pkg::*;

	record_t    rec_s1;
	logic       last_s1;
	logic       valid_s1;
	record_t    kept_q;
	logic       holding_q;
	logic       error_q;
	logic       out_valid_q;
	logic [7:0] tag_q;
	logic       failed_q;

	logic       go_s1;
	logic       in_xfer;
	cmp_t       cmp;
	logic       take_new;
	logic       err_now;
	logic       err_next;
	logic [7:0] tag_next;

	// The input stage advances unless a last record waits on a full output.
	assign go_s1    = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || go_s1;
	assign in_xfer  = in_valid && in_ready;

	// Comparison against the kept record and the update decision.
	always_comb begin
		cmp      = compare_rec(rec_s1, kept_q);
		take_new = 1'b0;
		err_now  = 1'b0;
		if (!error_q) begin
			if (!holding_q) begin
				take_new = 1'b1;
			end else begin
				err_now  = (cmp == CMP_ERROR);
				take_new = (cmp == CMP_A_BETTER) || (cmp == CMP_A_TOPO);
			end
		end
		err_next = error_q || err_now;
		tag_next = err_next ? 8'd0 : (take_new ? rec_s1.record_tag : kept_q.record_tag);
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rec_s1 <= '{gm_identity, gm_priority1, gm_clock_class, gm_clock_accuracy,
				gm_log_variance, gm_priority2, hop_count, sender_identity,
				receiver_identity, receiver_port, record_tag};
			last_s1 <= last_record;
		end
	end

	// Kept record payload.
	always_ff @(posedge clk) begin
		if (go_s1 && take_new) begin
			kept_q <= rec_s1;
		end
	end

	// Output result payload.
	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			tag_q    <= tag_next;
			failed_q <= err_next;
		end
	end

	// Control state: stage valid, list state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			holding_q   <= 1'b0;
			error_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (go_s1) begin
				if (last_s1) begin
					holding_q <= 1'b0;
					error_q   <= 1'b0;
				end else begin
					holding_q <= holding_q || take_new;
					error_q   <= err_next;
				end
			end
			if (go_s1 && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign chosen_tag = tag_q;
	assign failed     = failed_q;

endmodule

### rtl/bmrs_checker.sv
// ---------------------------------------------------------------------------
// bmrs_checker
// Port-level checks for the best master record selector.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "best_master_record_select_assert.svh"

module bmrs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [63:0] gm_identity,
	input logic [7:0]  gm_priority1,
	input logic [7:0]  gm_clock_class,
	input logic [7:0]  gm_clock_accuracy,
	input logic [15:0] gm_log_variance,
	input logic [7:0]  gm_priority2,
	input logic [15:0] hop_count,
	input logic [63:0] sender_identity,
	input logic [63:0] receiver_identity,
	input logic [15:0] receiver_port,
	input logic [7:0]  record_tag,
	input logic        last_record,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  chosen_tag,
	input logic        failed
);

	// A stalled result holds its value.
	`BMRS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(chosen_tag) && $stable(failed), "result changed while stalled")

	// A failed list never reports a tag.
	`BMRS_ASSERT(a_fail_tag, out_valid && failed |-> chosen_tag == 8'd0, "tag given with failure")

	// A fresh result follows the transfer of a last record, which passes the
	// input stage and then the output register.
	`BMRS_ASSERT(a_result_cause, $rose(out_valid) |-> $past(in_valid && in_ready && last_record, 2), "result without a last record")

	// No result is shown during reset.
	`BMRS_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid, "result valid in reset")

endmodule

bind best_master_record_select bmrs_checker u_bmrs_checker (.*);

### dv/best_master_record_select_tb.sv
// ---------------------------------------------------------------------------
// best_master_record_select_tb
// Checks the best master record selector against a behavioral predictor of
// the dataset comparison. Short directed lists walk each ranking step, then
// random lists with shared grandmasters, senders and ports force ties,
// topology decisions and identity errors. Both channels stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module best_master_record_select_tb;
	import bmrs_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 650;

	// Expected outcome of one list.
	typedef struct {
		logic [7:0] tag;
		logic       fail;
	} verdict_t;

	// Tracks the kept record per list and holds the verdicts still to come.
	class master_scoreboard;
		record_t  kept;
		bit       have_kept;
		bit       tie_error;
		verdict_t verdicts[$];
		int       errors;

		function new();
			kept      = '0;
			have_kept = 1'b0;
			tie_error = 1'b0;
			errors    = 0;
		endfunction

		function cmp_t lower_wins(logic [63:0] x, logic [63:0] y);
			if (x < y)
				return CMP_A_BETTER;
			return CMP_B_BETTER;
		endfunction

		// Ranks new record a against the kept record.
		function cmp_t rank_new(record_t a);
			int hop_a;
			int hop_b;
			hop_a = int'(a.hop_count);
			hop_b = int'(kept.hop_count);
			if (a.gm_identity != kept.gm_identity) begin
				if (a.gm_priority1 != kept.gm_priority1)
					return lower_wins(64'(a.gm_priority1), 64'(kept.gm_priority1));
				if (a.gm_clock_class != kept.gm_clock_class)
					return lower_wins(64'(a.gm_clock_class), 64'(kept.gm_clock_class));
				if (a.gm_clock_accuracy != kept.gm_clock_accuracy)
					return lower_wins(64'(a.gm_clock_accuracy),
						64'(kept.gm_clock_accuracy));
				if (a.gm_log_variance != kept.gm_log_variance)
					return lower_wins(64'(a.gm_log_variance), 64'(kept.gm_log_variance));
				if (a.gm_priority2 != kept.gm_priority2)
					return lower_wins(64'(a.gm_priority2), 64'(kept.gm_priority2));
				return lower_wins(a.gm_identity, kept.gm_identity);
			end
			// Same grandmaster: hop counts first, without wrap.
			if (hop_a > hop_b + 1)
				return CMP_B_BETTER;
			if (hop_a + 1 < hop_b)
				return CMP_A_BETTER;
			if (hop_a > hop_b) begin
				if (a.receiver_identity < a.sender_identity)
					return CMP_B_BETTER;
				if (a.receiver_identity > a.sender_identity)
					return CMP_B_TOPO;
				return CMP_ERROR;
			end
			if (hop_a < hop_b) begin
				if (kept.receiver_identity < kept.sender_identity)
					return CMP_A_BETTER;
				if (kept.receiver_identity > kept.sender_identity)
					return CMP_A_TOPO;
				return CMP_ERROR;
			end
			if (a.sender_identity < kept.sender_identity)
				return CMP_A_TOPO;
			if (a.sender_identity > kept.sender_identity)
				return CMP_B_TOPO;
			if (a.receiver_port > kept.receiver_port)
				return CMP_B_TOPO;
			if (a.receiver_port < kept.receiver_port)
				return CMP_A_TOPO;
			return CMP_ERROR;
		endfunction

		// Notes one accepted record and predicts the verdict at the end of a list.
		function void note_record(record_t r, logic last);
			cmp_t     c;
			verdict_t v;
			if (!tie_error) begin
				if (!have_kept) begin
					kept      = r;
					have_kept = 1'b1;
				end else begin
					c = rank_new(r);
					if (c == CMP_ERROR)
						tie_error = 1'b1;
					else if (c == CMP_A_BETTER || c == CMP_A_TOPO)
						kept = r;
				end
			end
			if (last) begin
				v.tag  = tie_error ? 8'd0 : kept.record_tag;
				v.fail = tie_error;
				verdicts.push_back(v);
				kept      = '0;
				have_kept = 1'b0;
				tie_error = 1'b0;
			end
		endfunction

		// Compares one accepted result with the oldest verdict.
		function void check_result(logic [7:0] tag, logic fail);
			verdict_t v;
			if (verdicts.size() == 0) begin
				$error("unexpected result: chosen_tag %0d failed %0d", tag, fail);
				errors++;
				return;
			end
			v = verdicts.pop_front();
			if (tag !== v.tag) begin
				$error("chosen_tag: expected %0d, actual %0d", v.tag, tag);
				errors++;
			end
			if (fail !== v.fail) begin
				$error("failed: expected %0d, actual %0d", v.fail, fail);
				errors++;
			end
		endfunction

		function int pending();
			return verdicts.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] gm_identity;
	logic [7:0]  gm_priority1;
	logic [7:0]  gm_clock_class;
	logic [7:0]  gm_clock_accuracy;
	logic [15:0] gm_log_variance;
	logic [7:0]  gm_priority2;
	logic [15:0] hop_count;
	logic [63:0] sender_identity;
	logic [63:0] receiver_identity;
	logic [15:0] receiver_port;
	logic [7:0]  record_tag;
	logic        last_record;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  chosen_tag;
	logic        failed;

	master_scoreboard sb = new();
	bit               calm = 1'b0;
	int               quiet_cycles = 0;

	best_master_record_select dut (.*);

	// 20 ns clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result side stalls at random except in the calm stretch.
	always @(negedge clk) begin
		out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 32);
	end

	// Sample both channels, feed the scoreboard, and watch for a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_record({gm_identity, gm_priority1, gm_clock_class,
					gm_clock_accuracy, gm_log_variance, gm_priority2, hop_count,
					sender_identity, receiver_identity, receiver_port, record_tag},
					last_record);
			if (out_valid && out_ready)
				sb.check_result(chosen_tag, failed);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("best_master_record_select_tb: FAIL");
				$finish;
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// A record with every field random.
	function automatic record_t rand_record();
		logic [319:0] bits;
		bits = {rand64(), rand64(), rand64(), rand64(), rand64()};
		return bits[$bits(record_t)-1:0];
	endfunction

	// Mostly the common value, sometimes an extreme or a random value.
	function automatic logic [63:0] mix(logic [63:0] common, logic [63:0] mask);
		case ($urandom_range(9))
			0: return mask;
			1: return 64'd0;
			2, 3: return rand64() & mask;
			default: return common;
		endcase
	endfunction

	// Drives one record and holds it until its transfer.
	task automatic send_record(record_t r, logic last);
		while (!calm && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid          <= 1'b1;
		gm_identity       <= r.gm_identity;
		gm_priority1      <= r.gm_priority1;
		gm_clock_class    <= r.gm_clock_class;
		gm_clock_accuracy <= r.gm_clock_accuracy;
		gm_log_variance   <= r.gm_log_variance;
		gm_priority2      <= r.gm_priority2;
		hop_count         <= r.hop_count;
		sender_identity   <= r.sender_identity;
		receiver_identity <= r.receiver_identity;
		receiver_port     <= r.receiver_port;
		record_tag        <= r.record_tag;
		last_record       <= last;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Each ranking step in turn, then the error cases.
	task automatic send_directed();
		record_t b;
		record_t k;
		record_t r;
		b = '0;
		b.gm_identity       = 64'h0011_2233_4455_6677;
		b.gm_priority1      = 8'h80;
		b.gm_clock_class    = 8'h80;
		b.gm_clock_accuracy = 8'h80;
		b.gm_log_variance   = 16'h8000;
		b.gm_priority2      = 8'h80;
		b.hop_count         = 16'd10;
		b.sender_identity   = 64'h1000;
		b.receiver_identity = 64'h2000;
		b.receiver_port     = 16'd5;
		b.record_tag        = 8'd1;

		// Single-record lists at both extremes.
		send_record('1, 1'b1);
		send_record('0, 1'b1);

		// Different grandmasters: each quality field decides once.
		send_record(b, 1'b0);
		k = b; k.gm_identity = 64'h0011_2233_4455_6678; k.gm_priority1 = 8'h7F;
		k.record_tag = 8'd2;
		send_record(k, 1'b0);
		r = k; r.gm_identity = '1; r.gm_clock_class = 8'h81; r.record_tag = 8'd3;
		send_record(r, 1'b0);
		k.gm_identity = 64'd0; k.gm_clock_accuracy = 8'h7F; k.record_tag = 8'd4;
		send_record(k, 1'b0);
		r = k; r.gm_identity = 64'd5; r.gm_log_variance = 16'hFFFF; r.record_tag = 8'd5;
		send_record(r, 1'b0);
		k.gm_identity = 64'd5; k.gm_priority2 = 8'h00; k.record_tag = 8'd6;
		send_record(k, 1'b0);
		k.gm_identity = 64'd3; k.record_tag = 8'd7;
		send_record(k, 1'b0);
		r = k; r.gm_identity = 64'd4; r.record_tag = 8'd8;
		send_record(r, 1'b1);

		// Same grandmaster: hop distance and topology decisions.
		k = b; k.record_tag = 8'd10;
		send_record(k, 1'b0);
		r = k; r.hop_count = 16'd13; r.record_tag = 8'd11;
		send_record(r, 1'b0);
		k.hop_count = 16'd5; k.receiver_identity = 64'h0100; k.record_tag = 8'd12;
		send_record(k, 1'b0);
		r = k; r.hop_count = 16'd6; r.receiver_identity = 64'h0500; r.record_tag = 8'd13;
		send_record(r, 1'b0);
		r.receiver_identity = 64'h3000; r.record_tag = 8'd14;
		send_record(r, 1'b0);
		k.hop_count = 16'd4; k.receiver_identity = 64'h4000; k.record_tag = 8'd15;
		send_record(k, 1'b0);
		k.hop_count = 16'd3; k.record_tag = 8'd16;
		send_record(k, 1'b0);
		k.sender_identity = 64'h0800; k.record_tag = 8'd17;
		send_record(k, 1'b0);
		r = k; r.sender_identity = 64'h0900; r.record_tag = 8'd18;
		send_record(r, 1'b0);
		r = k; r.receiver_port = 16'hFFFF; r.record_tag = 8'd19;
		send_record(r, 1'b0);
		r = k; r.receiver_port = 16'd0; r.record_tag = 8'd20;
		send_record(r, 1'b1);

		// Identity tie, then records that must be ignored.
		k = b; k.record_tag = 8'd30;
		send_record(k, 1'b0);
		k.record_tag = 8'd31;
		send_record(k, 1'b0);
		r = b; r.gm_priority1 = 8'h00; r.record_tag = 8'd32;
		send_record(r, 1'b0);
		r.record_tag = 8'd33;
		send_record(r, 1'b1);

		// Tie found on the last record itself, at the top of the hop range.
		k = b; k.hop_count = 16'hFFFF; k.receiver_identity = k.sender_identity;
		k.record_tag = 8'd40;
		send_record(k, 1'b0);
		r = k; r.hop_count = 16'hFFFE; r.record_tag = 8'd41;
		send_record(r, 1'b1);
	endtask

	// One list of records sharing a few grandmasters, senders and ports.
	task automatic send_random_list(int n);
		record_t     proto;
		record_t     r;
		logic [63:0] gm_pool[3];
		logic [63:0] snd_pool[4];
		proto = rand_record();
		if ($urandom_range(9) == 0)
			proto.hop_count = 16'hFFFF;
		else if ($urandom_range(9) == 0)
			proto.hop_count = 16'd0;
		foreach (gm_pool[i])
			gm_pool[i] = mix(rand64(), '1);
		foreach (snd_pool[i])
			snd_pool[i] = mix(rand64(), '1);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 8) begin
				r = rand_record();
			end else begin
				r.gm_identity       = gm_pool[$urandom_range(2)];
				r.gm_priority1      = 8'(mix(64'(proto.gm_priority1), 64'hFF));
				r.gm_clock_class    = 8'(mix(64'(proto.gm_clock_class), 64'hFF));
				r.gm_clock_accuracy = 8'(mix(64'(proto.gm_clock_accuracy), 64'hFF));
				r.gm_log_variance   = 16'(mix(64'(proto.gm_log_variance), 64'hFFFF));
				r.gm_priority2      = 8'(mix(64'(proto.gm_priority2), 64'hFF));
				if ($urandom_range(9) == 0)
					r.hop_count = 16'(mix(64'(proto.hop_count), 64'hFFFF));
				else
					r.hop_count = proto.hop_count + 16'($urandom_range(4)) - 16'd2;
				r.sender_identity   = snd_pool[$urandom_range(3)];
				if ($urandom_range(99) < 12)
					r.receiver_identity = r.sender_identity;
				else
					r.receiver_identity = mix(snd_pool[$urandom_range(3)], '1);
				r.receiver_port     = 16'(mix(64'(proto.receiver_port), 64'hFFFF));
				r.record_tag        = 8'($urandom);
			end
			send_record(r, i == n - 1);
		end
	endtask

	initial begin
		int sent;
		int n;
		in_valid          = 1'b0;
		gm_identity       = '0;
		gm_priority1      = '0;
		gm_clock_class    = '0;
		gm_clock_accuracy = '0;
		gm_log_variance   = '0;
		gm_priority2      = '0;
		hop_count         = '0;
		sender_identity   = '0;
		receiver_identity = '0;
		receiver_port     = '0;
		record_tag        = '0;
		last_record       = 1'b0;
		// Assert reset slightly after time zero so the falling edge is seen.
		#1 arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_directed();

		// Random lists, with one stretch where neither side stalls.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			calm = (sent >= 250 && sent < 400);
			n = ($urandom_range(19) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
			send_random_list(n);
			sent += n;
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("best_master_record_select_tb: PASS");
		else
			$display("best_master_record_select_tb: FAIL");
		$finish;
	end

endmodule
